// File: rtl/fac_pkg.sv
`timescale 1ns / 1ps

package fac_pkg;

	localparam int TAG_W     = 16;
	localparam int COORD_W   = 16;
	localparam int HALF_W    = 15;
	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 14;

	// Plane registers present in the register file
	localparam int REG_COUNT = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 4 * COEF_W;

	// n * c and |n| * h products and the per-plane sums
	localparam int PROD_W = COEF_W + COORD_W;
	localparam int RAD_W  = COEF_W + HALF_W;
	localparam int DIST_W = PROD_W + 2;
	localparam int RSUM_W = RAD_W + 2;
	localparam int SUM_W  = DIST_W + 2;

	localparam int IN_FIELDS_W = TAG_W + 3 * COORD_W + 3 * HALF_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((TAG_W + 1 + 7) / 8) * 8;

	typedef struct packed {
		logic signed [COEF_W-1:0] offset;
		logic signed [COEF_W-1:0] nz;
		logic signed [COEF_W-1:0] ny;
		logic signed [COEF_W-1:0] nx;
	} plane_t;

	typedef struct packed {
		logic        [HALF_W-1:0]  hz;
		logic        [HALF_W-1:0]  hy;
		logic        [HALF_W-1:0]  hx;
		logic signed [COORD_W-1:0] cz;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cx;
	} box_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} pipe_ctrl_t;

endpackage

// File: rtl/fac_plane_regs.sv
`timescale 1ns / 1ps

module fac_plane_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fac_pkg::CFG_W-1:0]      cfg_data,
	output fac_pkg::plane_t                planes [fac_pkg::REG_COUNT]
);

	fac_pkg::plane_t plane_q [fac_pkg::REG_COUNT];

	assign cfg_ready = 1'b1;

	// indexes past the last plane match no entry and are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < fac_pkg::REG_COUNT; r++) begin
				plane_q[r] <= '0;
			end
		end else if (cfg_valid) begin
			for (int r = 0; r < fac_pkg::REG_COUNT; r++) begin
				if (cfg_index == fac_pkg::CFG_IDX_W'(r)) begin
					plane_q[r] <= fac_pkg::plane_t'(cfg_data);
				end
			end
		end
	end

	assign planes = plane_q;

endmodule

// File: rtl/fac_plane_test.sv
`timescale 1ns / 1ps

module fac_plane_test (
	input  logic                clk,
	input  logic                arst_n,
	input  fac_pkg::pipe_ctrl_t ctrl,
	input  fac_pkg::plane_t     plane,
	input  fac_pkg::box_t       box,
	output logic                pass_s3
);

	logic [fac_pkg::COEF_W-1:0] abs_x;
	logic [fac_pkg::COEF_W-1:0] abs_y;
	logic [fac_pkg::COEF_W-1:0] abs_z;

	logic signed [fac_pkg::PROD_W-1:0] dot_x_s1;
	logic signed [fac_pkg::PROD_W-1:0] dot_y_s1;
	logic signed [fac_pkg::PROD_W-1:0] dot_z_s1;
	logic        [fac_pkg::RAD_W-1:0]  rad_x_s1;
	logic        [fac_pkg::RAD_W-1:0]  rad_y_s1;
	logic        [fac_pkg::RAD_W-1:0]  rad_z_s1;

	logic signed [fac_pkg::DIST_W-1:0] dist_s2;
	logic        [fac_pkg::RSUM_W-1:0] rad_s2;
	logic signed [fac_pkg::DIST_W-1:0] d_scaled;
	logic signed [fac_pkg::SUM_W-1:0]  total;

	// -2.0 gives 0x8000, which reads as +2.0 unsigned
	assign abs_x = plane.nx[fac_pkg::COEF_W-1] ? (~plane.nx + 1'b1) : plane.nx;
	assign abs_y = plane.ny[fac_pkg::COEF_W-1] ? (~plane.ny + 1'b1) : plane.ny;
	assign abs_z = plane.nz[fac_pkg::COEF_W-1] ? (~plane.nz + 1'b1) : plane.nz;

	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			dot_x_s1 <= fac_pkg::PROD_W'(plane.nx) * fac_pkg::PROD_W'(box.cx);
			dot_y_s1 <= fac_pkg::PROD_W'(plane.ny) * fac_pkg::PROD_W'(box.cy);
			dot_z_s1 <= fac_pkg::PROD_W'(plane.nz) * fac_pkg::PROD_W'(box.cz);
			rad_x_s1 <= fac_pkg::RAD_W'(abs_x) * fac_pkg::RAD_W'(box.hx);
			rad_y_s1 <= fac_pkg::RAD_W'(abs_y) * fac_pkg::RAD_W'(box.hy);
			rad_z_s1 <= fac_pkg::RAD_W'(abs_z) * fac_pkg::RAD_W'(box.hz);
		end
	end

	// distance is an integer; bring it to the Q.14 scale of the products
	assign d_scaled = fac_pkg::DIST_W'(plane.offset) <<< fac_pkg::FRAC_BITS;

	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			dist_s2 <= fac_pkg::DIST_W'(dot_x_s1) + fac_pkg::DIST_W'(dot_y_s1)
				+ fac_pkg::DIST_W'(dot_z_s1) + d_scaled;
			rad_s2  <= fac_pkg::RSUM_W'(rad_x_s1) + fac_pkg::RSUM_W'(rad_y_s1)
				+ fac_pkg::RSUM_W'(rad_z_s1);
		end
	end

	assign total = fac_pkg::SUM_W'(dist_s2) + $signed({1'b0, (fac_pkg::SUM_W-1)'(rad_s2)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_s3 <= 1'b1;
		end else if (ctrl.en_s3) begin
			pass_s3 <= ~total[fac_pkg::SUM_W-1];
		end
	end

endmodule

// File: rtl/frustum_aabb_cull.sv
`timescale 1ns / 1ps

// Frustum cull of axis-aligned boxes against up to six planes. Each box
// (tag, center, half-extents) comes out as its tag plus a visible flag:
// visible is 0 when, for some plane, n.c + d*2^14 + |n|.h < 0 in Q.14.
// One box per cycle is taken and delivered while m_axis does not stall; a
// box's result passes through three arithmetic stages (the multiplier rows,
// the per-plane sums and the sign test), then the output register, before
// it is presented on m_axis. The user must write planes over the cfg
// channel only while no box is in flight; the block does not enforce it.
// Entries past the sixth never cull. cfg_ready is always high.
module frustum_aabb_cull #(
	parameter int NUM_PLANES = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// box_tag, center_x, center_y, center_z, half_x, half_y, half_z, zero pad
	input  logic [fac_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// out_tag, visible, zero pad
	output logic [fac_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fac_pkg::CFG_W-1:0]       cfg_data
);

	fac_pkg::plane_t    planes [fac_pkg::REG_COUNT];
	fac_pkg::box_t      box;
	fac_pkg::pipe_ctrl_t ctrl;

	logic [fac_pkg::TAG_W-1:0] in_tag;
	logic [fac_pkg::TAG_W-1:0] tag_s1;
	logic [fac_pkg::TAG_W-1:0] tag_s2;
	logic [fac_pkg::TAG_W-1:0] tag_s3;
	logic [fac_pkg::TAG_W-1:0] tag_s4;
	logic                      v_s1;
	logic                      v_s2;
	logic                      v_s3;
	logic                      v_s4;
	logic                      vis_s4;
	logic                      en_s4;
	logic [NUM_PLANES-1:0]     pass_s3;

	localparam int BoxLo = fac_pkg::TAG_W;
	localparam int BoxW  = fac_pkg::IN_FIELDS_W - fac_pkg::TAG_W;

	assign in_tag = s_axis_tdata[fac_pkg::TAG_W-1:0];
	assign box    = fac_pkg::box_t'(s_axis_tdata[BoxLo +: BoxW]);

	fac_plane_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes    (planes)
	);

	// each stage moves when it is empty or the one after it moves
	assign en_s4         = ~v_s4 | m_axis_tready;
	assign ctrl.en_s3    = ~v_s3 | en_s4;
	assign ctrl.en_s2    = ~v_s2 | ctrl.en_s3;
	assign ctrl.en_s1    = ~v_s1 | ctrl.en_s2;
	assign s_axis_tready = ctrl.en_s1;

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		if (p < fac_pkg::REG_COUNT) begin : g_test
			fac_plane_test u_test (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.plane   (planes[p]),
				.box     (box),
				.pass_s3 (pass_s3[p])
			);
		end else begin : g_empty
			// no register behind this plane: all-zero, always passes
			assign pass_s3[p] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ctrl.en_s1) v_s1 <= s_axis_tvalid;
			if (ctrl.en_s2) v_s2 <= v_s1;
			if (ctrl.en_s3) v_s3 <= v_s2;
			if (en_s4)      v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s1) tag_s1 <= in_tag;
		if (ctrl.en_s2) tag_s2 <= tag_s1;
		if (ctrl.en_s3) tag_s3 <= tag_s2;
		if (en_s4) begin
			tag_s4 <= tag_s3;
			vis_s4 <= &pass_s3;
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {{(fac_pkg::OUT_TDATA_W - fac_pkg::TAG_W - 1){1'b0}}, vis_s4, tag_s4};

`ifndef NO_ASSERTIONS
	a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted box did not enter the first stage");

	a_full_blocks_input : assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while the whole pipeline is stalled");

	a_s3_reaches_output : assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (m_axis_tready || !m_axis_tvalid) |=> m_axis_tvalid)
		else $error("result in the last stage did not reach the output");

	a_stall_holds_s3 : assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && m_axis_tvalid && !m_axis_tready |=> v_s3 && $stable(tag_s3))
		else $error("last stage changed while the output was stalled");
`endif

endmodule
